FILE: rtl/heat_tracked_record_index_assert.svh
// assertion macros shared by the record index rtl
// no dependencies
`ifndef HEAT_TRACKED_RECORD_INDEX_ASSERT_SVH
`define HEAT_TRACKED_RECORD_INDEX_ASSERT_SVH
// implication checked on every clock edge outside reset
`define HTRI_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define HTRI_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/htri_pkg.sv
// types and constants for the record index
// no dependencies
package htri_pkg;
    localparam int unsigned EntriesDef = 4096;
    localparam int unsigned HeaderBytesDef = 24;
    localparam int unsigned OffW = 40;
    localparam int unsigned SizeW = 32;
    localparam int unsigned KeyW = 64;
    localparam int unsigned HeatW = 8;
    localparam logic [HeatW-1:0] HeatMax = 8'd255;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0, OP_READ = 3'd1, OP_DELETE = 3'd2,
        OP_TICK = 3'd3, OP_PROMOTE = 3'd4, OP_FLUSH = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_FULL = 2'd2, ST_INDEX_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_SIZE = 2'd0, CFG_COLD = 2'd1, CFG_HOT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] key_digest;
        logic [15:0] key_len;
        logic [23:0] val_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [39:0] record_offset;
        logic [31:0] rec_bytes;
        logic [7:0]  heat;
        logic        hot;
    } t_out_item;

    // datapath commands from the controller
    typedef struct packed {
        logic load;        // capture input item
        logic rd_en;       // issue read at rd_addr
        logic rd_last;     // read address comes from last entry
        logic wr_new;      // write captured item at count
        logic wr_heat;     // write modified heat at match slot
        logic wr_move;     // write last entry data at match slot
        logic wr_cool;     // write cooled heat at scan slot
        logic cnt_inc;
        logic cnt_dec;
        logic flush;
        logic adv_ptr;
        logic take_match;  // latch entry data read this cycle as match
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;         // registered read data key matches
        logic fits;
        logic room;
        logic empty;
        logic [2:0] op;
    } t_sts;
endpackage

FILE: rtl/heat_tracked_record_index.sv
// top level of the heat tracked record index
// depends on htri_pkg, htri_ctrl, htri_datapath, htri_ram, assert header
//
//  channel | direction | handshake
//  in      | input     | i_in_valid / o_in_stall
//  out     | output    | o_out_valid / i_out_stall
//  cfg     | input     | i_cfg_valid / o_cfg_ready
//
// write, flush and unused ops go from decode to done; promote, read and delete scan
// to the matching slot, then read writes back heat and delete moves the last entry;
// a miss or a tick walks every entry, as the single ram read port reads them in turn.
// reset is synchronous, clears counters and pointer; entry rams are not cleared.
// one item at a time: input stalls while an item is in work; a result held by
// the receiver keeps the next item in its last state until the transfer.
`include "heat_tracked_record_index_assert.svh"
module heat_tracked_record_index import htri_pkg::*; #(
    parameter int unsigned Entries = EntriesDef,
    parameter int unsigned HeaderBytes = HeaderBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [39:0] i_cfg_data
);
    localparam int unsigned CW = $clog2(Entries+1);
    logic [39:0] r_max_size;
    logic [7:0] r_cold, r_hot;
    t_cmd cmd;
    t_sts sts;
    logic [CW-1:0] scan, count;
    t_status status;
    logic report;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= '0;
            r_cold <= 8'd16;
            r_hot <= 8'd64;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_SIZE: r_max_size <= i_cfg_data;
                CFG_COLD: r_cold <= i_cfg_data[7:0];
                CFG_HOT: r_hot <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    htri_ctrl #(.Entries(Entries)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_sts(sts), .i_count(count), .o_cmd(cmd), .o_scan(scan),
        .o_status(status), .o_report(report));

    htri_datapath #(.Entries(Entries), .HeaderBytes(HeaderBytes)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_data), .i_max_size(r_max_size),
        .i_cold(r_cold), .i_hot(r_hot), .i_cmd(cmd), .i_scan(scan),
        .i_status(status), .i_report(report), .o_sts(sts), .o_count(count),
        .o_result(o_out_data));

    `HTRI_ASSERT_IMP(a_count_le, i_clk, i_rst_n, 1'b1, count <= CW'(Entries), "count overflow")
    `HTRI_ASSERT_NXT(a_load_busy, i_clk, i_rst_n, cmd.load, o_in_stall, "accepted while busy")
    `HTRI_ASSERT_IMP(a_one_write, i_clk, i_rst_n, 1'b1,
        $countones({cmd.wr_new, cmd.wr_heat, cmd.wr_move, cmd.wr_cool}) <= 1, "write clash")
endmodule

FILE: rtl/htri_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module htri_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/htri_datapath.sv
// entry stores, counters and result register of the record index
// depends on htri_pkg and htri_ram
module htri_datapath import htri_pkg::*; #(
    parameter int unsigned Entries = EntriesDef,
    parameter int unsigned HeaderBytes = HeaderBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  logic [39:0] i_max_size,
    input  logic [7:0] i_cold,
    input  logic [7:0] i_hot,
    input  t_cmd       i_cmd,
    input  logic [$clog2(Entries+1)-1:0] i_scan,
    input  t_status    i_status,
    input  logic       i_report,
    output t_sts       o_sts,
    output logic [$clog2(Entries+1)-1:0] o_count,
    output t_out_item  o_result
);
    localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int unsigned CW = $clog2(Entries+1);

    t_in_item r_item;
    logic [CW-1:0] r_count;
    logic [OffW-1:0] r_append;
    logic [SizeW-1:0] size;
    logic [AW-1:0] r_mslot;
    logic [OffW-1:0] r_moff;
    logic [SizeW-1:0] r_msize;
    logic [HeatW-1:0] r_mheat;
    logic [KeyW-1:0] rd_key;
    logic [OffW-1:0] rd_off;
    logic [SizeW-1:0] rd_size;
    logic [HeatW-1:0] rd_heat;
    logic [AW-1:0] rd_addr, r_raddr, waddr;
    logic we_all, we_heat;
    logic [KeyW-1:0] w_key;
    logic [OffW-1:0] w_off;
    logic [SizeW-1:0] w_size;
    logic [HeatW-1:0] w_heat;
    logic [OffW:0] end_sum;
    logic [CW-1:0] last;
    t_out_item n_result;

    assign size = SizeW'(HeaderBytes) + 32'(r_item.key_len) + 32'(r_item.val_bytes);
    assign end_sum = {1'b0, r_append} + 41'(size);
    assign last = r_count - 1'b1;
    assign rd_addr = i_cmd.rd_last ? last[AW-1:0] : i_scan[AW-1:0];

    always_comb begin
        we_all = i_cmd.wr_new | i_cmd.wr_move;
        we_heat = we_all | i_cmd.wr_heat | i_cmd.wr_cool;
        waddr = r_mslot;
        w_key = rd_key;
        w_off = rd_off;
        w_size = rd_size;
        w_heat = rd_heat;
        if (i_cmd.wr_new) begin
            waddr = r_count[AW-1:0];
            w_key = r_item.key_digest;
            w_off = r_append;
            w_size = size;
            w_heat = i_cold;
        end else if (i_cmd.wr_heat) begin
            w_heat = r_mheat;
        end else if (i_cmd.wr_cool) begin
            waddr = r_raddr;
            w_heat = (rd_heat != '0) ? rd_heat - 1'b1 : rd_heat;
        end
    end

    htri_ram #(.Width(KeyW), .Depth(Entries)) u_key (
        .i_clk, .i_we(we_all), .i_waddr(waddr), .i_wdata(w_key),
        .i_raddr(rd_addr), .o_rdata(rd_key));
    htri_ram #(.Width(OffW), .Depth(Entries)) u_off (
        .i_clk, .i_we(we_all), .i_waddr(waddr), .i_wdata(w_off),
        .i_raddr(rd_addr), .o_rdata(rd_off));
    htri_ram #(.Width(SizeW), .Depth(Entries)) u_size (
        .i_clk, .i_we(we_all), .i_waddr(waddr), .i_wdata(w_size),
        .i_raddr(rd_addr), .o_rdata(rd_size));
    htri_ram #(.Width(HeatW), .Depth(Entries)) u_heat (
        .i_clk, .i_we(we_heat), .i_waddr(waddr), .i_wdata(w_heat),
        .i_raddr(rd_addr), .o_rdata(rd_heat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_append <= '0;
        end else begin
            if (i_cmd.flush) begin
                r_count <= '0;
                r_append <= '0;
            end else begin
                if (i_cmd.cnt_inc) r_count <= r_count + 1'b1;
                if (i_cmd.cnt_dec) r_count <= last;
                if (i_cmd.adv_ptr) r_append <= end_sum[OffW-1:0];
            end
        end
    end

    always_comb begin
        n_result = '0;
        n_result.status = i_status;
        if (t_op'(r_item.op) == OP_WRITE) begin
            n_result.rec_bytes = size;
            if (i_status != ST_FULL) n_result.record_offset = r_append;
            if (i_status == ST_OK) n_result.heat = i_cold;
        end else if (i_report) begin
            n_result.record_offset = r_moff;
            n_result.rec_bytes = r_msize;
            n_result.heat = r_mheat;
            n_result.hot = (t_op'(r_item.op) == OP_PROMOTE) && (r_mheat >= i_hot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.rd_en) r_raddr <= rd_addr;
        if (i_cmd.take_match) begin
            r_mslot <= r_raddr;
            r_moff <= rd_off;
            r_msize <= rd_size;
            // a read raises heat, saturating
            r_mheat <= (t_op'(r_item.op) == OP_READ && rd_heat != HeatMax)
                ? rd_heat + 1'b1 : rd_heat;
        end
        if (i_cmd.out_load) o_result <= n_result;
    end

    assign o_sts.hit = (rd_key == r_item.key_digest);
    assign o_sts.fits = (i_max_size == '0) || (end_sum <= {1'b0, i_max_size});
    assign o_sts.room = (r_count < CW'(Entries));
    assign o_sts.empty = (r_count == '0);
    assign o_sts.op = r_item.op;
    assign o_count = r_count;
endmodule

FILE: rtl/htri_ctrl.sv
// controller sequencing one item at a time over the entry stores
// depends on htri_pkg
module htri_ctrl import htri_pkg::*; #(
    parameter int unsigned Entries = EntriesDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_sts  i_sts,
    input  logic [$clog2(Entries+1)-1:0] i_count,
    output t_cmd  o_cmd,
    output logic [$clog2(Entries+1)-1:0] o_scan,
    output t_status o_status,
    output logic  o_report
);
    localparam int unsigned CW = $clog2(Entries+1);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_MOVE, S_MOVE_WR, S_COOL, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_scan, n_scan;
    logic r_out_valid;
    t_status r_status, n_status;
    logic r_report, n_report;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_scan = r_scan;
    assign o_status = n_status;
    assign o_report = n_report;

    always_comb begin
        n_state = r_state;
        n_scan = r_scan;
        n_status = r_status;
        n_report = r_report;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_scan = '0;
                    n_status = ST_OK;
                    n_report = 1'b0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (t_op'(i_sts.op))
                    OP_WRITE: begin
                        if (!i_sts.fits) n_status = ST_FULL;
                        else if (i_sts.room) begin
                            o_cmd.wr_new = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end else n_status = ST_INDEX_FULL;
                        n_state = S_DONE;
                    end
                    OP_READ, OP_DELETE, OP_PROMOTE, OP_TICK: begin
                        if (i_sts.empty) begin
                            if (t_op'(i_sts.op) != OP_TICK) n_status = ST_NOT_FOUND;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_scan = r_scan + 1'b1;
                            n_state = (t_op'(i_sts.op) == OP_TICK) ? S_COOL : S_SCAN;
                        end
                    end
                    OP_FLUSH: begin
                        o_cmd.flush = 1'b1;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                // ram data for the previous address is valid here
                if (i_sts.hit) begin
                    o_cmd.take_match = 1'b1;
                    n_report = 1'b1;
                    if (t_op'(i_sts.op) == OP_DELETE) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_last = 1'b1;
                        n_state = S_MOVE;
                    end else if (t_op'(i_sts.op) == OP_READ) begin
                        n_state = S_MOVE_WR;
                    end else n_state = S_DONE;
                end else if (r_scan == i_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_scan = r_scan + 1'b1;
                end
            end
            S_MOVE: begin
                // last entry data on ram output, copy into freed slot
                o_cmd.wr_move = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                n_state = S_DONE;
            end
            S_MOVE_WR: begin
                o_cmd.wr_heat = 1'b1;
                n_state = S_DONE;
            end
            S_COOL: begin
                o_cmd.wr_cool = 1'b1;
                if (r_scan == i_count) n_state = S_DONE;
                else begin
                    o_cmd.rd_en = 1'b1;
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    // pointer moves with the result so the old offset is reported
                    if (t_op'(i_sts.op) == OP_WRITE && r_status != ST_FULL) begin
                        o_cmd.adv_ptr = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan <= '0;
            r_out_valid <= 1'b0;
            r_status <= ST_OK;
            r_report <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan <= n_scan;
            r_status <= n_status;
            r_report <= n_report;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end
endmodule
